/* sv/md5_pkg.sv */
// md5 message digest: shared types, initial chain values and round tables
// used by the round datapath and the top level; no dependencies
package md5_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  localparam int unsigned BufDepth = 16;
  localparam int unsigned BufAddrW = 4;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [31:0] PadWord = 32'h00000080;
  localparam logic [2:0]  FullBytes = 3'd4;
  localparam logic [BufAddrW-1:0] LenLoPos = 4'd14;
  localparam logic [BufAddrW-1:0] LastPos  = 4'd15;
  localparam logic [5:0]  LastRound = 6'd63;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_DONE  = 5'b01000,
    ST_SPARE = 5'b10000
  } md5_state_e;

  function automatic logic [BufAddrW-1:0] md5_msg_idx(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] idx;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = r;
      2'd1:    idx = {r[1:0], 2'b00} + r + 4'd1;
      2'd2:    idx = {r[2:0], 1'b0} + r + 4'd5;
      default: idx = {r[0], 3'b000} - r;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] md5_k(input logic [5:0] rnd);
    logic [31:0] k;
    case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

/* sv/md5_ram.sv */
// md5 message digest: generic single-write, single-read ram with registered read
// no dependencies
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/md5_round.sv */
// md5 message digest: one compression round (boolean function, adds, rotate)
// depends on md5_pkg
module md5_round import md5_pkg::*; (
  input  md5_abcd_t   cur_i,
  input  logic [31:0] msg_i,
  input  logic [5:0]  rnd_i,
  output md5_abcd_t   nxt_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;

  always_comb begin
    case (rnd_i[5:4])
      2'd0:    f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      2'd1:    f = (cur_i.b & cur_i.d) | (cur_i.c & ~cur_i.d);
      2'd2:    f = cur_i.b ^ cur_i.c ^ cur_i.d;
      default: f = cur_i.c ^ (cur_i.b | ~cur_i.d);
    endcase
  end

  assign sum      = cur_i.a + f + msg_i + md5_k(rnd_i);
  assign rot_wide = {sum, sum} << md5_rot(rnd_i);

  assign nxt_o.a = cur_i.d;
  assign nxt_o.b = rot_wide[63:32] + cur_i.b;
  assign nxt_o.c = cur_i.b;
  assign nxt_o.d = cur_i.c;

endmodule

/* sv/md5_message_digest_unit.sv */
// md5 message digest: top level with word buffer, padding sequencer and round loop
// depends on md5_pkg, md5_ram and md5_round
//
// usage
// - input channel: message_word_i with valid_bytes_i and last_word_i, handshake
//   in_valid_i / in_stall_o; a word is taken when valid is high and stall low
// - output channel: digest_a_o..digest_d_o, handshake out_valid_o / out_stall_i
// - words are written into a 16-entry buffer ram, one per cycle unless stalled;
//   the sixteenth word of a block starts the rounds, one round per cycle,
//   during which the input is stalled
// - on a last word the block writes the pad and length words one per cycle,
//   then compresses once or twice; afterwards the digest is loaded into the output
//   register and the chain returns to its initial values
// - a new message may start while the digest waits in the output register;
//   only the next digest waits for the old one to be taken
// - reset clears the chain, counters and output valid; no clearing pass is
//   needed since every buffer entry is written before it is read
module md5_message_digest_unit import md5_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] message_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_a_o,
  output logic [31:0] digest_b_o,
  output logic [31:0] digest_c_o,
  output logic [31:0] digest_d_o
);

  md5_state_e state_q, state_d;
  md5_abcd_t  chain_q, chain_d;
  md5_abcd_t  work_q, work_d;
  md5_abcd_t  round_nxt;
  md5_abcd_t  dig_q, dig_d;
  logic [BufAddrW-1:0] pos_q, pos_d;
  logic [60:0] len_q, len_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        fin_q, fin_d;
  logic        need80_q, need80_d;
  logic        lo_done_q, lo_done_d;
  logic        hi_done_q, hi_done_d;
  logic        out_valid_q, out_valid_d;

  logic                we;
  logic [31:0]         wdata;
  logic [BufAddrW-1:0] raddr;
  logic [31:0]         rdata;
  logic                accept;
  logic [2:0]          vb;
  logic [31:0]         last_data;
  logic [63:0]         bit_len;

  md5_ram #(
    .Width(32),
    .Depth(BufDepth)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(pos_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  md5_round u_round (
    .cur_i(work_q),
    .msg_i(rdata),
    .rnd_i(rnd_q),
    .nxt_o(round_nxt)
  );

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign vb      = (valid_bytes_i > FullBytes) ? FullBytes : valid_bytes_i;
  assign bit_len = {len_q, 3'b000};
  assign raddr   = (state_q == ST_ROUND) ? md5_msg_idx(rnd_q + 6'd1) : md5_msg_idx(6'd0);

  always_comb begin
    case (vb)
      3'd0:    last_data = PadWord;
      3'd1:    last_data = {16'h0000, PadWord[7:0], message_word_i[7:0]};
      3'd2:    last_data = {8'h00, PadWord[7:0], message_word_i[15:0]};
      3'd3:    last_data = {PadWord[7:0], message_word_i[23:0]};
      default: last_data = message_word_i;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    work_d      = work_q;
    dig_d       = dig_q;
    pos_d       = pos_q;
    len_d       = len_q;
    rnd_d       = rnd_q;
    fin_d       = fin_q;
    need80_d    = need80_q;
    lo_done_d   = lo_done_q;
    hi_done_d   = hi_done_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    wdata       = message_word_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          we = 1'b1;
          if (last_word_i) begin
            len_d    = len_q + 61'(vb);
            wdata    = last_data;
            fin_d    = 1'b1;
            need80_d = (vb == FullBytes);
            state_d  = ST_PAD;
          end else begin
            len_d = len_q + 61'd4;
          end
        end
      end
      ST_PAD: begin
        we = 1'b1;
        if (need80_q) begin
          wdata    = PadWord;
          need80_d = 1'b0;
        end else if (pos_q == LenLoPos) begin
          wdata     = bit_len[31:0];
          lo_done_d = 1'b1;
        end else if (pos_q == LastPos && lo_done_q) begin
          wdata     = bit_len[63:32];
          hi_done_d = 1'b1;
        end else begin
          wdata = 32'h0;
        end
      end
      ST_ROUND: begin
        work_d = round_nxt;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == LastRound) begin
          chain_d.a = chain_q.a + round_nxt.a;
          chain_d.b = chain_q.b + round_nxt.b;
          chain_d.c = chain_q.c + round_nxt.c;
          chain_d.d = chain_q.d + round_nxt.d;
          if (!fin_q) begin
            state_d = ST_IDLE;
          end else if (hi_done_q) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          dig_d       = chain_q;
          out_valid_d = 1'b1;
          chain_d     = '{a: InitA, b: InitB, c: InitC, d: InitD};
          len_d       = '0;
          pos_d       = '0;
          fin_d       = 1'b0;
          lo_done_d   = 1'b0;
          hi_done_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // every buffer write advances the position; the sixteenth starts the rounds
    if (we) begin
      pos_d = pos_q + 4'd1;
      if (pos_q == LastPos) begin
        work_d  = chain_q;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= '{a: InitA, b: InitB, c: InitC, d: InitD};
      pos_q       <= '0;
      len_q       <= '0;
      rnd_q       <= '0;
      fin_q       <= 1'b0;
      need80_q    <= 1'b0;
      lo_done_q   <= 1'b0;
      hi_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      rnd_q       <= rnd_d;
      fin_q       <= fin_d;
      need80_q    <= need80_d;
      lo_done_q   <= lo_done_d;
      hi_done_q   <= hi_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    dig_q  <= dig_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign digest_a_o  = dig_q.a;
  assign digest_b_o  = dig_q.b;
  assign digest_c_o  = dig_q.c;
  assign digest_d_o  = dig_q.d;

endmodule
